/* rtl/core/bee_pkg.sv */
// ----------------------------------------------------------------------------
// Band energy estimator package
// Shared widths, reset values, the queue entry type and the back-end states.
// ----------------------------------------------------------------------------
package bee_pkg;

	// default configuration of the block
	localparam int MAX_BANDS_DEF      = 64;
	localparam int COEF_BITS_DEF      = 24;
	localparam int MAX_BAND_WIDTH_DEF = 64;

	// fixed field widths
	localparam int COEF_W   = 24;
	localparam int ENERGY_W = 47;
	localparam int BAND_W   = 6;
	localparam int HBS_W    = 7;
	localparam int SUM_W    = 53;
	localparam int CNT_W    = 7;

	localparam logic [HBS_W-1:0] HBS_RESET = HBS_W'(62);

	// ratio for the near-Nyquist test: 30 = 32 - 2
	localparam int NYQ_W = SUM_W + 5;

	// divider: a padded dividend, several quotient bits per cycle
	localparam int DIV_BITS_PER_CYCLE = 8;
	localparam int DIV_CYCLES         = (SUM_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
	localparam int DIV_W              = DIV_CYCLES * DIV_BITS_PER_CYCLE;
	localparam int DIV_CNT_W          = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one closed band, handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  count;
		logic [BAND_W-1:0] band;
		logic              last;
	} band_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SUM,
		BK_EMIT
	} back_state_t;

endpackage

/* rtl/core/bee_front.sv */
// ----------------------------------------------------------------------------
// Band energy estimator front end
// Accepts coefficients, squares them and sums each band; closed bands are
// pushed to the queue with their count and band index.
// ----------------------------------------------------------------------------
module bee_front import bee_pkg::*; #(
	parameter int MAX_BANDS      = MAX_BANDS_DEF,
	parameter int COEF_BITS      = COEF_BITS_DEF,
	parameter int MAX_BAND_WIDTH = MAX_BAND_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [COEF_W-1:0] coefficient,
	input  logic              band_end,
	input  logic              frame_end,
	input  logic              q_full,
	output logic              q_push,
	output band_job_t         q_data
);

	localparam int SQ_W   = 2 * COEF_BITS - 1;
	localparam int ACC_W  = SQ_W + $clog2(MAX_BAND_WIDTH);
	localparam int BCNT_W = $clog2(MAX_BAND_WIDTH + 1);
	localparam int BIDX_W = $clog2(MAX_BANDS);

	logic [BCNT_W-1:0] count_q;
	logic [BIDX_W-1:0] band_q;
	logic [ACC_W-1:0]  acc_q;

	logic                 v_s1, take_s1, bend_s1, fend_s1;
	logic [COEF_BITS-1:0] mag_s1;
	logic [BCNT_W-1:0]    cnt_s1;
	logic [BIDX_W-1:0]    band_s1;

	logic              v_s2, bend_s2, fend_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic [BCNT_W-1:0] cnt_s2;
	logic [BIDX_W-1:0] band_s2;

	logic                 en, take, close_in, close_s2;
	logic [COEF_BITS-1:0] raw, mag;
	logic [BCNT_W-1:0]    cnt_next;
	logic [2*COEF_BITS-1:0] prod;
	logic [ACC_W-1:0]     acc_sum;

	assign close_s2 = bend_s2 | fend_s2;
	// hold the whole pipe while a closed band waits for queue space
	assign en       = !(v_s2 && close_s2 && q_full);
	assign in_ready = en;

	assign raw      = coefficient[COEF_BITS-1:0];
	assign mag      = raw[COEF_BITS-1] ? (~raw + COEF_BITS'(1)) : raw;
	assign take     = count_q < BCNT_W'(MAX_BAND_WIDTH);
	assign cnt_next = count_q + BCNT_W'(take);
	assign close_in = band_end | frame_end;

	assign prod    = mag_s1 * mag_s1;
	assign acc_sum = acc_q + ACC_W'(sq_s2);

	assign q_push       = en && v_s2 && close_s2;
	assign q_data.sum   = SUM_W'(acc_sum);
	assign q_data.count = CNT_W'(cnt_s2);
	assign q_data.band  = BAND_W'(band_s2);
	assign q_data.last  = fend_s2;

	// band counters run at accept time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			band_q  <= '0;
		end else if (en && in_valid) begin
			count_q <= close_in ? '0 : cnt_next;
			if (frame_end) begin
				band_q <= '0;
			end else if (band_end && band_q != BIDX_W'(MAX_BANDS - 1)) begin
				band_q <= band_q + BIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= close_s2 ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= take ? mag : '0;
			take_s1 <= take;
			bend_s1 <= band_end;
			fend_s1 <= frame_end;
			cnt_s1  <= cnt_next;
			band_s1 <= band_q;

			sq_s2   <= take_s1 ? prod[SQ_W-1:0] : '0;
			bend_s2 <= bend_s1;
			fend_s2 <= fend_s1;
			cnt_s2  <= cnt_s1;
			band_s2 <= band_s1;
		end
	end

endmodule

/* rtl/core/bee_queue.sv */
// ----------------------------------------------------------------------------
// Band energy estimator queue
// Short register FIFO of closed bands between front and back.
// ----------------------------------------------------------------------------
module bee_queue import bee_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  band_job_t push_data,
	input  logic      pop,
	output band_job_t head,
	output logic      full,
	output logic      empty
);

	band_job_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full band queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty band queue");
`endif

endmodule

/* rtl/core/bee_back.sv */
// ----------------------------------------------------------------------------
// Band energy estimator back end
// Divides each band sum by its count, keeps the low and high frame sums and
// delivers one result per band through an output register.
// ----------------------------------------------------------------------------
module bee_back import bee_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [HBS_W-1:0]    high_band_start,
	input  band_job_t           q_head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ENERGY_W-1:0] band_energy,
	output logic [BAND_W-1:0]   band_number,
	output logic                near_nyquist,
	output logic                last_of_frame
);

	back_state_t state_q, state_d;

	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIV_W-1:0]     quo_q, quo_d;
	logic [CNT_W-1:0]     rem_q, rem_d, div_q;
	logic [BAND_W-1:0]    band_q;
	logic                 last_q;
	logic [SUM_W-1:0]     low_q, high_q;
	logic                 out_valid_q;

	logic [ENERGY_W-1:0] energy;
	logic [SUM_W:0]      low_add, high_add;
	logic [NYQ_W-1:0]    low30;
	logic                flag, emit, is_high;

	assign energy  = quo_q[ENERGY_W-1:0];
	assign is_high = {1'b0, band_q} >= high_band_start;
	assign low_add  = {1'b0, low_q}  + (SUM_W + 1)'(energy);
	assign high_add = {1'b0, high_q} + (SUM_W + 1)'(energy);
	assign low30   = {low_q, 5'b0} - {4'b0, low_q, 1'b0};
	assign flag    = (NYQ_W'(high_q) > low30);
	assign out_valid = out_valid_q;

	// several restoring-division steps per cycle on a narrow remainder
	always_comb begin
		logic [CNT_W:0] t;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
			t     = {rem_d, quo_d[DIV_W-1]};
			quo_d = {quo_d[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				rem_d    = CNT_W'(t - {1'b0, div_q});
				quo_d[0] = 1'b1;
			end else begin
				rem_d = t[CNT_W-1:0];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					state_d = BK_SUM;
				end
			end
			BK_SUM: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			div_cnt_q   <= '0;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				div_cnt_q <= '0;
			end else if (state_q == BK_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (state_q == BK_SUM) begin
				if (is_high) begin
					high_q <= high_add[SUM_W] ? '1 : high_add[SUM_W-1:0];
				end else begin
					low_q <= low_add[SUM_W] ? '1 : low_add[SUM_W-1:0];
				end
			end
			if (emit && last_q) begin
				low_q  <= '0;
				high_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			quo_q  <= DIV_W'(q_head.sum);
			rem_q  <= '0;
			div_q  <= q_head.count;
			band_q <= q_head.band;
			last_q <= q_head.last;
		end else if (state_q == BK_DIV) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
		if (emit) begin
			band_energy   <= energy;
			band_number   <= band_q;
			near_nyquist  <= last_q & flag;
			last_of_frame <= last_q;
		end
	end

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < div_q))
		else $error("division remainder not below divisor");

	a_frame_clears_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_q) |=> (low_q == '0 && high_q == '0))
		else $error("frame sums not cleared after last band");

	a_emit_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !emit)
		else $error("result overwritten while waiting");
`endif

endmodule

/* rtl/core/band_energy_estimator.sv */
// Band energy estimator. Coefficients (signed Q1.23) enter one per cycle on
// the input channel unless the front stalls, each marked with band_end and
// frame_end; frame_end also closes the open band. Each band yields one
// transaction on the output channel: the truncated mean square of its
// coefficients (unsigned Q1.46), its index within the frame and, on the
// frame's last band, last_of_frame and the near_nyquist flag (high-band
// energy sum above 30 times the low-band sum, bands from high_band_start
// upward counting as high). Coefficients past MAX_BAND_WIDTH in one band
// are dropped from its mean; band indexes stop at MAX_BANDS-1. The back end
// pops each closed band, divides it (eight quotient bits per cycle on a
// 56-bit dividend), updates the frame sums and emits. A two-entry queue
// lets the front keep taking coefficients while the back end divides; the
// front stalls only when a band closes with the queue full. The output
// register holds a finished result while the next band is worked on. The
// always-ready configuration channel writes high_band_start; the user must
// do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
// Band energy estimator top level
// Configuration register, front end, band queue and back end.
// ----------------------------------------------------------------------------
module band_energy_estimator import bee_pkg::*; #(
	parameter int MAX_BANDS      = MAX_BANDS_DEF,
	parameter int COEF_BITS      = COEF_BITS_DEF,
	parameter int MAX_BAND_WIDTH = MAX_BAND_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [HBS_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [COEF_W-1:0]   coefficient,
	input  logic                band_end,
	input  logic                frame_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ENERGY_W-1:0] band_energy,
	output logic [BAND_W-1:0]   band_number,
	output logic                near_nyquist,
	output logic                last_of_frame
);

	logic [HBS_W-1:0] hbs_q;
	logic             q_push, q_pop, q_full, q_empty;
	band_job_t        q_in, q_head;

	// the register write is always accepted and is registered in hbs_q
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbs_q <= HBS_RESET;
		end else if (cfg_valid) begin
			hbs_q <= cfg_data;
		end
	end

	// square and sum each band, push it when it closes
	bee_front #(
		.MAX_BANDS      (MAX_BANDS),
		.COEF_BITS      (COEF_BITS),
		.MAX_BAND_WIDTH (MAX_BAND_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coefficient (coefficient),
		.band_end    (band_end),
		.frame_end   (frame_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	// decouple front and back so each can stall on its own
	bee_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// divide, update frame sums, deliver results
	bee_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.high_band_start (hbs_q),
		.q_head          (q_head),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.band_energy     (band_energy),
		.band_number     (band_number),
		.near_nyquist    (near_nyquist),
		.last_of_frame   (last_of_frame)
	);

endmodule

/* bench/tb_band_energy_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band energy estimator testbench
// Drives marked spectral coefficients into the block, predicts every band
// energy result with a cycle-free model kept here, and compares the results
// field by field under random idling on both channels and output back-pressure.
// ----------------------------------------------------------------------------
module tb_band_energy_estimator import bee_pkg::*; ();

	localparam int CLK_PERIOD   = 10;
	localparam int MAX_IDLE     = 13;   // longest per-transaction gap on either side
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 40;   // back end latency plus a receiver stall, with margin
	localparam int IDLE_LIMIT   = 2000; // cycles without any transaction before giving up
	localparam int NYQ_RATIO    = 30;
	localparam int PHASE_ITEMS  = 50;

	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [HBS_W-1:0]  HBS_TOP  = HBS_W'(MAX_BANDS_DEF);

	// one expected band result
	typedef struct {
		logic [ENERGY_W-1:0] energy;
		logic [BAND_W-1:0]   band;
		logic                flag;
		logic                frame_last;
	} band_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [HBS_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [COEF_W-1:0]   coefficient;
	logic                band_end;
	logic                frame_end;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ENERGY_W-1:0] band_energy;
	logic [BAND_W-1:0]   band_number;
	logic                near_nyquist;
	logic                last_of_frame;

	band_energy_estimator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.coefficient  (coefficient),
		.band_end     (band_end),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.band_energy  (band_energy),
		.band_number  (band_number),
		.near_nyquist (near_nyquist),
		.last_of_frame(last_of_frame)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Energy model: the band and frame state the block is expected to hold
	// ------------------------------------------------------------------
	logic [SUM_W-1:0]  model_square_sum = '0;
	logic [CNT_W-1:0]  model_count      = '0;
	logic [BAND_W-1:0] model_band       = '0;
	logic [SUM_W-1:0]  model_low_sum    = '0;
	logic [SUM_W-1:0]  model_high_sum   = '0;
	logic [HBS_W-1:0]  model_hbs        = HBS_RESET;

	band_result_t pending_bands[$];

	int  mismatch_count = 0;
	int  coefs_sent     = 0;
	bit  in_steady      = 1'b0;  // sender offers back to back when set
	logic out_steady    = 1'b0;  // receiver never stalls when set
	logic sink_hold     = 1'b0;  // long receiver hold-off in progress
	int  sink_wait      = 0;
	int  idle_cycles    = 0;

	function automatic logic [SUM_W-1:0] add_saturating(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = a + b;
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	// Fold one accepted coefficient into the model; queue a result on a band close.
	task automatic accumulate_coefficient(input logic [COEF_W-1:0] c, input logic be,
		input logic fe);
		logic [COEF_W-1:0] mag;
		logic [SUM_W-1:0]  mean;
		band_result_t      r;
		// coefficients past the band width limit leave sum and count alone
		if (model_count < CNT_W'(MAX_BAND_WIDTH_DEF)) begin
			mag = c[COEF_W-1] ? (~c + 1'b1) : c;
			model_square_sum += SUM_W'(mag) * SUM_W'(mag);
			model_count++;
		end
		if (!be && !fe)
			return;
		mean = model_square_sum / SUM_W'(model_count);
		r.energy = mean[ENERGY_W-1:0];
		r.band   = model_band;
		if (HBS_W'(model_band) >= model_hbs)
			model_high_sum = add_saturating(model_high_sum, mean);
		else
			model_low_sum = add_saturating(model_low_sum, mean);
		model_square_sum = '0;
		model_count      = '0;
		if (fe) begin
			r.flag       = 64'(model_high_sum) > 64'(model_low_sum) * 64'(NYQ_RATIO);
			r.frame_last = 1'b1;
			model_band     = '0;
			model_low_sum  = '0;
			model_high_sum = '0;
		end else begin
			r.flag       = 1'b0;
			r.frame_last = 1'b0;
			// band index sticks at the top once the frame has too many bands
			if (model_band < BAND_W'(MAX_BANDS_DEF - 1))
				model_band++;
		end
		pending_bands.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Result checking and the receiver side
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_band_result();
		band_result_t want;
		if (pending_bands.size() == 0) begin
			note_mismatch("band result with none outstanding", 64'(band_number), 64'(0));
			return;
		end
		want = pending_bands.pop_front();
		if (band_energy !== want.energy)
			note_mismatch("band_energy", 64'(band_energy), 64'(want.energy));
		if (band_number !== want.band)
			note_mismatch("band_number", 64'(band_number), 64'(want.band));
		if (near_nyquist !== want.flag)
			note_mismatch("near_nyquist", 64'(near_nyquist), 64'(want.flag));
		if (last_of_frame !== want.frame_last)
			note_mismatch("last_of_frame", 64'(last_of_frame), 64'(want.frame_last));
	endtask

	// Check each output transaction, then draw the stall before the next one.
	// The long hold-off overrides the drawn stall while it lasts.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			check_band_result();
			sink_wait = out_steady ? 0 : $urandom_range(0, MAX_IDLE);
		end else if (sink_wait > 0) begin
			sink_wait--;
		end
		out_ready <= (sink_wait == 0) && !sink_hold;
	end

	// Watchdog: count cycles in which no channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offer one coefficient; called right after a rising edge. Valid stays high
	// after acceptance so a back-to-back transaction needs no second assignment.
	task automatic send_coef(input logic [COEF_W-1:0] c, input logic be, input logic fe);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		coefficient <= c;
		band_end    <= be;
		frame_end   <= fe;
		do @(posedge clk); while (!in_ready);
		accumulate_coefficient(c, be, fe);
		coefs_sent++;
	endtask

	// Drop valid and wait until every outstanding band has come out and the
	// back end has had time to finish anything still in flight.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_bands.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_high_band_start(input logic [HBS_W-1:0] v);
		settle_block();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_hbs = v;
	endtask

	// Random coefficient of a given magnitude range: bits = 0 gives zero,
	// bits = COEF_W the full signed range.
	function automatic logic [COEF_W-1:0] rand_coef(input int unsigned bits);
		logic [31:0] r;
		r = $urandom;
		if (bits == 0)
			return '0;
		return COEF_W'($signed(r[COEF_W-1:0]) >>> (COEF_W - bits));
	endfunction

	// Well-formed frame with random content; sometimes the frame end comes
	// without a band end, sometimes a band runs past the width limit.
	task automatic send_random_frame(input int unsigned max_bands);
		int unsigned n_bands;
		int unsigned len;
		int unsigned bits;
		logic        closes_frame;
		logic        be;
		n_bands = $urandom_range(1, max_bands);
		for (int b = 0; b < n_bands; b++) begin
			len  = ($urandom_range(0, 23) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
			bits = $urandom_range(0, COEF_W);
			for (int k = 0; k < len; k++) begin
				closes_frame = (k == len - 1) && (b == n_bands - 1);
				be = (k == len - 1);
				if (closes_frame && $urandom_range(0, 3) == 0)
					be = 1'b0;
				send_coef(rand_coef(bits), be, closes_frame);
			end
		end
	endtask

	// Unstructured items: full-range coefficients with random marks.
	task automatic send_noise(input int unsigned n);
		for (int k = 0; k < n; k++)
			send_coef(COEF_W'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Field extremes and mark combinations under the reset threshold.
	task automatic test_directed();
		send_coef('0, 1'b1, 1'b0);                 // zero band
		send_coef(COEF_MAX, 1'b1, 1'b0);           // largest positive square
		send_coef(COEF_MIN, 1'b1, 1'b0);           // most negative, square 2^46
		send_coef(-COEF_W'(1), 1'b0, 1'b0);        // truncated mean: 27 / 3
		send_coef(COEF_W'(1), 1'b0, 1'b0);
		send_coef(COEF_W'(5), 1'b1, 1'b0);
		send_coef(COEF_W'(123), 1'b0, 1'b0);       // frame end closes the open band
		send_coef(-COEF_W'(7), 1'b0, 1'b1);
		send_coef('0, 1'b1, 1'b1);                 // one-coefficient frame
		send_coef(COEF_MAX, 1'b0, 1'b0);
		send_coef(COEF_MIN, 1'b1, 1'b1);
		send_coef(COEF_W'(24'h5A5A5A), 1'b0, 1'b0);
		send_coef(COEF_W'(24'hA5A5A5), 1'b1, 1'b1);
	endtask

	// Flag just above and at the 30x boundary, and with both sums zero.
	task automatic test_near_nyquist();
		write_high_band_start(HBS_W'(1));
		send_coef(COEF_W'(1), 1'b1, 1'b0);         // low = 1
		send_coef(COEF_W'(7), 1'b0, 1'b0);         // high = (49 + 36 + 9) / 3 = 31
		send_coef(COEF_W'(6), 1'b0, 1'b0);
		send_coef(-COEF_W'(3), 1'b1, 1'b1);
		send_coef(-COEF_W'(1), 1'b1, 1'b0);        // low = 1
		send_coef(COEF_W'(5), 1'b0, 1'b0);         // high = 61 / 2 = 30, not above
		send_coef(COEF_W'(6), 1'b1, 1'b1);
		write_high_band_start('0);
		send_coef('0, 1'b1, 1'b1);
	endtask

	// Bands longer than the width limit: the excess must not reach the mean,
	// and a frame end on a dropped coefficient still closes the frame.
	task automatic test_wide_band();
		write_high_band_start(HBS_RESET);
		for (int k = 0; k < MAX_BAND_WIDTH_DEF + 6; k++)
			send_coef(k < MAX_BAND_WIDTH_DEF ? COEF_MIN : COEF_MAX, 1'b0, 1'b0);
		send_coef('0, 1'b1, 1'b0);
		for (int k = 0; k < MAX_BAND_WIDTH_DEF; k++)
			send_coef(COEF_W'(1), 1'b0, 1'b0);
		send_coef(COEF_MIN, 1'b0, 1'b0);
		send_coef(COEF_MIN, 1'b0, 1'b1);
	endtask

	// Frames with more bands than indexes and enough full-scale energy to
	// saturate the high sum, then the low sum.
	task automatic test_frame_limits();
		write_high_band_start('0);
		in_steady = 1'b1;
		for (int b = 0; b < 2 * MAX_BANDS_DEF + 4; b++)
			send_coef(COEF_MIN, 1'b1, b == 2 * MAX_BANDS_DEF + 3);
		write_high_band_start(HBS_TOP);
		for (int b = 0; b < 2 * MAX_BANDS_DEF + 4; b++)
			send_coef(COEF_MIN, 1'b1, b == 2 * MAX_BANDS_DEF + 3);
		in_steady = 1'b0;
	endtask

	// Hold the receiver off for a long stretch while the sender keeps
	// closing bands back to back, so the band queue fills and input stalls.
	task automatic test_output_backpressure();
		settle_block();
		in_steady = 1'b1;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
		join_none
		for (int k = 0; k < 40; k++)
			send_coef(COEF_W'($urandom), 1'b1, k == 39);
		in_steady = 1'b0;
	endtask

	// One threshold setting, then mostly well-formed frames plus some noise.
	// The open frame is closed at the end so the next write finds it idle.
	task automatic run_random_phase(input logic [HBS_W-1:0] hbs);
		int start_count;
		write_high_band_start(hbs);
		in_steady = ($urandom_range(0, 3) == 0);
		out_steady <= ($urandom_range(0, 3) == 0);
		start_count = coefs_sent;
		while (coefs_sent - start_count < PHASE_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				send_noise($urandom_range(1, 12));
			else
				send_random_frame(($urandom_range(0, 19) == 0) ? 70 : 12);
		end
		send_coef(rand_coef($urandom_range(0, COEF_W)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic test_random_sweep();
		run_random_phase('0);
		run_random_phase(HBS_TOP);
		run_random_phase(HBS_W'(1));
		run_random_phase(HBS_W'(MAX_BANDS_DEF - 1));
		run_random_phase(HBS_RESET);
		run_random_phase(HBS_W'($urandom_range(0, MAX_BANDS_DEF)));
		run_random_phase(HBS_W'($urandom_range(0, 12)));
		run_random_phase(HBS_W'($urandom_range(0, 12)));
		run_random_phase(HBS_W'(2));
		run_random_phase(HBS_W'(4));
		in_steady = 1'b0;
		out_steady <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = HBS_RESET;
		in_valid    = 1'b0;
		coefficient = '0;
		band_end    = 1'b0;
		frame_end   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_near_nyquist();
		test_wide_band();
		test_frame_limits();
		test_output_backpressure();
		test_random_sweep();
		settle_block();

		if (pending_bands.size() != 0)
			note_mismatch("band results never delivered", 64'(pending_bands.size()), 64'(0));
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
